// ===== rtl/core/spmmd_pkg.sv =====
// Shared types, constants and helpers for the stereo peak meter / min-max decimator.
`timescale 1ns / 1ps

package spmmd_pkg;

	localparam int SAMPLE_W     = 24;
	localparam int MAG_W        = SAMPLE_W - 1;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 8;
	localparam int GAIN_W       = 16;
	localparam int COUNT_W      = 16;
	localparam int POINT_SLOT_W = 9;
	localparam int RING_SLOTS   = 512;
	localparam int SLOT_W       = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int PROD_W       = MAG_W + GAIN_W;

	localparam logic [CFG_DATA_W-1:0] DECIM_RESET = CFG_DATA_W'(256);
	localparam logic [GAIN_W-1:0]     GAIN_RESET  = GAIN_W'(62259);
	localparam logic [MAG_W-1:0]      MAG_MAX     = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECIMATION = CFG_IDX_W'(0),
		CFG_DECAY_GAIN = CFG_IDX_W'(1)
	} cfg_reg_e;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       block_end;
	} in_item_t;

	typedef struct packed {
		logic                       point_valid;
		logic [POINT_SLOT_W-1:0]    point_slot;
		logic signed [SAMPLE_W-1:0] min_left;
		logic [MAG_W-1:0]           max_left;
		logic signed [SAMPLE_W-1:0] min_right;
		logic [MAG_W-1:0]           max_right;
		logic                       meter_valid;
		logic [MAG_W-1:0]           level_left;
		logic [MAG_W-1:0]           level_right;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_item_t;

	// per-sample step control shared by both channels
	typedef struct packed {
		logic adv;
		logic point;
		logic blk_end;
	} chan_ctl_t;

	// |x| with the most negative code saturated
	function automatic logic [MAG_W-1:0] mag_sat(input logic signed [SAMPLE_W-1:0] x);
		logic [SAMPLE_W-1:0] neg;
		neg = -x;
		if (!x[SAMPLE_W-1]) begin
			return x[MAG_W-1:0];
		end else if (neg[SAMPLE_W-1]) begin
			return MAG_MAX;
		end else begin
			return neg[MAG_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/spmmd_if.sv =====
// Valid/ready channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps

interface spmmd_in_if;
	import spmmd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spmmd_out_if;
	import spmmd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spmmd_cfg_if;
	import spmmd_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/spmmd_chan.sv =====
// One audio channel: running min/max, block peak and decaying meter level.
`timescale 1ns / 1ps

module spmmd_chan (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  spmmd_pkg::chan_ctl_t                 ctl,
	input  logic signed [spmmd_pkg::SAMPLE_W-1:0] sample,
	input  logic [spmmd_pkg::MAG_W-1:0]          mag,
	input  logic [spmmd_pkg::GAIN_W-1:0]         gain,
	output logic signed [spmmd_pkg::SAMPLE_W-1:0] min_nx,
	output logic [spmmd_pkg::MAG_W-1:0]          max_nx,
	output logic [spmmd_pkg::MAG_W-1:0]          level_nx
);
	import spmmd_pkg::*;

	logic signed [SAMPLE_W-1:0] run_min_q;
	logic [MAG_W-1:0]           run_max_q;
	logic [MAG_W-1:0]           peak_q;
	logic [MAG_W-1:0]           meter_q;
	logic [MAG_W-1:0]           peak_nx;
	logic [PROD_W-1:0]          prod;
	logic [MAG_W-1:0]           decayed;

	always_comb begin
		peak_nx = (mag > peak_q) ? mag : peak_q;
		min_nx  = (sample < run_min_q) ? sample : run_min_q;
		max_nx  = (!sample[SAMPLE_W-1] && (sample[MAG_W-1:0] > run_max_q)) ?
			sample[MAG_W-1:0] : run_max_q;
		prod     = PROD_W'(meter_q) * PROD_W'(gain);
		decayed  = prod[PROD_W-1:GAIN_W];
		level_nx = (peak_nx > decayed) ? peak_nx : decayed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= '0;
			run_max_q <= '0;
			peak_q    <= '0;
			meter_q   <= '0;
		end else if (ctl.adv) begin
			run_min_q <= ctl.point ? '0 : min_nx;
			run_max_q <= ctl.point ? '0 : max_nx;
			peak_q    <= ctl.blk_end ? '0 : peak_nx;
			if (ctl.blk_end) begin
				meter_q <= level_nx;
			end
		end
	end

	a_point_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv && ctl.point |=> run_min_q == '0 && run_max_q == '0)
		else $error("running min/max not cleared after point");

	a_block_clears_peak: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv && ctl.blk_end |=> peak_q == '0)
		else $error("block peak not cleared at block end");

	a_meter_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.adv && ctl.blk_end) |=> $stable(meter_q))
		else $error("meter level changed without block end");

endmodule

// ===== rtl/core/stereo_peak_meter_minmax_decimator.sv =====
// Top level: stereo peak meter with min/max waveform decimation.
// A sample transaction is accepted into the input register, and its result is then registered in the output register.
// Throughput: one sample per cycle while the result side takes results; the state
// update (count, min/max, peak compare and one 23x16 multiply per channel) is combinational.
// A sample causing no result never waits on the result side.
// Reset (arst_n low, asynchronous) clears the control and channel state and loads the register defaults.
`timescale 1ns / 1ps

module stereo_peak_meter_minmax_decimator (
	input  logic        clk,
	input  logic        arst_n,
	spmmd_in_if.sink    sample_ch,
	spmmd_out_if.source result_ch,
	spmmd_cfg_if.sink   cfg_ch
);
	import spmmd_pkg::*;

	logic [CFG_DATA_W-1:0] decim_q;
	logic [GAIN_W-1:0]     gain_q;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] left_s1;
	logic signed [SAMPLE_W-1:0] right_s1;
	logic [MAG_W-1:0]           mag_left_s1;
	logic [MAG_W-1:0]           mag_right_s1;
	logic                       blk_end_s1;

	logic [COUNT_W-1:0] chunk_count_q;
	logic [SLOT_W-1:0]  write_slot_q;
	logic [COUNT_W-1:0] cnt_inc;
	logic               point;
	logic               has_res;
	logic               adv;
	chan_ctl_t          ctl;

	logic signed [SAMPLE_W-1:0] min_left_nx;
	logic signed [SAMPLE_W-1:0] min_right_nx;
	logic [MAG_W-1:0]           max_left_nx;
	logic [MAG_W-1:0]           max_right_nx;
	logic [MAG_W-1:0]           level_left_nx;
	logic [MAG_W-1:0]           level_right_nx;

	out_item_t res;
	out_item_t out_q;
	logic      out_valid_q;

	// register writes
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DECIM_RESET;
			gain_q  <= GAIN_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.data.index)
				CFG_DECIMATION: decim_q <= cfg_ch.data.value;
				CFG_DECAY_GAIN: gain_q  <= GAIN_W'(cfg_ch.data.value);
				default: ;
			endcase
		end
	end

	// step control
	always_comb begin
		cnt_inc = chunk_count_q + COUNT_W'(1);
		point   = (cnt_inc == '0) || (cnt_inc >= COUNT_W'(decim_q));
		has_res = point || blk_end_s1;
		adv     = valid_s1 && (!has_res || !out_valid_q || result_ch.ready);
		ctl.adv     = adv;
		ctl.point   = point;
		ctl.blk_end = blk_end_s1;
	end

	assign sample_ch.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			left_s1      <= sample_ch.data.left_sample;
			right_s1     <= sample_ch.data.right_sample;
			mag_left_s1  <= mag_sat(sample_ch.data.left_sample);
			mag_right_s1 <= mag_sat(sample_ch.data.right_sample);
			blk_end_s1   <= sample_ch.data.block_end;
		end
	end

	// chunk counter and ring slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= '0;
			write_slot_q  <= '0;
		end else if (adv) begin
			chunk_count_q <= point ? '0 : cnt_inc;
			if (point) begin
				write_slot_q <= (write_slot_q == SLOT_W'(RING_SLOTS - 1)) ?
					'0 : write_slot_q + SLOT_W'(1);
			end
		end
	end

	spmmd_chan u_chan_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sample   (left_s1),
		.mag      (mag_left_s1),
		.gain     (gain_q),
		.min_nx   (min_left_nx),
		.max_nx   (max_left_nx),
		.level_nx (level_left_nx)
	);

	spmmd_chan u_chan_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sample   (right_s1),
		.mag      (mag_right_s1),
		.gain     (gain_q),
		.min_nx   (min_right_nx),
		.max_nx   (max_right_nx),
		.level_nx (level_right_nx)
	);

	// result assembly, unused half zeroed
	always_comb begin
		res             = '0;
		res.point_valid = point;
		res.meter_valid = blk_end_s1;
		if (point) begin
			res.point_slot = POINT_SLOT_W'(write_slot_q);
			res.min_left   = min_left_nx;
			res.max_left   = max_left_nx;
			res.min_right  = min_right_nx;
			res.max_right  = max_right_nx;
		end
		if (blk_end_s1) begin
			res.level_left  = level_left_nx;
			res.level_right = level_right_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_res) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			out_q <= res;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.data  = out_q;

	a_result_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> (result_ch.data.point_valid || result_ch.data.meter_valid))
		else $error("result transaction carries no event");

	a_point_resets_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && point |=> chunk_count_q == '0)
		else $error("chunk count not cleared after point");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ch.ready |-> (valid_s1 && result_ch.valid && !result_ch.ready))
		else $error("sample side stalled without a blocked result");

endmodule

// ===== verif/tb_stereo_peak_meter_minmax_decimator.sv =====
// Testbench for the stereo peak meter: predicts envelope points and meter levels per sample.
`timescale 1ns / 1ps

module tb_stereo_peak_meter_minmax_decimator;
	import spmmd_pkg::*;

	localparam int IDLE_PCT    = 18;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 4;

	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {MAG_W{1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {MAG_W{1'b1}}};
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(2);

	logic clk = 1'b0;
	logic arst_n;

	spmmd_in_if  sample_ch ();
	spmmd_out_if result_ch ();
	spmmd_cfg_if cfg_ch ();

	stereo_peak_meter_minmax_decimator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	in_item_t  sample_q[$];
	out_item_t envelope_meter_q[$];
	int        errors = 0;
	logic      no_idle;
	logic      hold_go;
	logic      hold_done;
	int        hold_cnt;
	int        stall_cycles;

	// predicted block state
	logic [CFG_DATA_W-1:0]      decim;
	logic [GAIN_W-1:0]          gain;
	logic [COUNT_W-1:0]         chunk_cnt;
	logic signed [SAMPLE_W-1:0] mn_l, mx_l, mn_r, mx_r;
	logic [MAG_W-1:0]           pk_l, pk_r, lvl_l, lvl_r;
	logic [SLOT_W-1:0]          slot;

	function automatic logic [MAG_W-1:0] peak_of(input logic signed [SAMPLE_W-1:0] x);
		int v;
		v = x;
		if (v < 0) v = -v;
		if (v > int'(MAG_MAX)) v = int'(MAG_MAX);
		return v[MAG_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] decayed(input logic [MAG_W-1:0] peak,
			input logic [MAG_W-1:0] old);
		logic [PROD_W-1:0] prod;
		prod = old * gain;
		return (peak > prod[PROD_W-1:GAIN_W]) ? peak : prod[PROD_W-1:GAIN_W];
	endfunction

	task automatic fold_sample(input in_item_t s);
		out_item_t r;
		logic      hit;
		logic [MAG_W-1:0] al, ar;
		r = '0;
		al = peak_of(s.left_sample);
		ar = peak_of(s.right_sample);
		if (al > pk_l) pk_l = al;
		if (ar > pk_r) pk_r = ar;
		if (s.left_sample < mn_l) mn_l = s.left_sample;
		if (s.left_sample > mx_l) mx_l = s.left_sample;
		if (s.right_sample < mn_r) mn_r = s.right_sample;
		if (s.right_sample > mx_r) mx_r = s.right_sample;
		chunk_cnt = chunk_cnt + 1'b1;
		hit = (chunk_cnt == '0) || (chunk_cnt >= decim);
		if (hit) begin
			r.point_valid = 1'b1;
			r.point_slot  = slot;
			r.min_left    = mn_l;
			r.max_left    = mx_l[MAG_W-1:0];
			r.min_right   = mn_r;
			r.max_right   = mx_r[MAG_W-1:0];
			slot = (slot == SLOT_W'(RING_SLOTS - 1)) ? '0 : slot + 1'b1;
			mn_l = '0;
			mx_l = '0;
			mn_r = '0;
			mx_r = '0;
			chunk_cnt = '0;
		end
		if (s.block_end) begin
			lvl_l = decayed(pk_l, lvl_l);
			lvl_r = decayed(pk_r, lvl_r);
			pk_l = '0;
			pk_r = '0;
			r.meter_valid = 1'b1;
			r.level_left  = lvl_l;
			r.level_right = lvl_r;
		end
		if (hit || s.block_end) envelope_meter_q = {envelope_meter_q, r};
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (sample_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				sample_ch.valid <= 1'b1;
				sample_ch.data  <= sample_q.pop_front();
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_cnt  <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			result_ch.ready <= 1'b0;
			if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			result_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: check results first, then predict from the sample accepted at this edge
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (result_ch.valid === 1'b1 && result_ch.ready) begin
				got = result_ch.data;
				if (envelope_meter_q.size() == 0) begin
					$error("result transaction with nothing pending");
					errors++;
				end else begin
					want = envelope_meter_q.pop_front();
					check_field("point_valid", want.point_valid, got.point_valid);
					check_field("point_slot", want.point_slot, got.point_slot);
					check_field("min_left", longint'(want.min_left), longint'(got.min_left));
					check_field("max_left", want.max_left, got.max_left);
					check_field("min_right", longint'(want.min_right), longint'(got.min_right));
					check_field("max_right", want.max_right, got.max_right);
					check_field("meter_valid", want.meter_valid, got.meter_valid);
					check_field("level_left", want.level_left, got.level_left);
					check_field("level_right", want.level_right, got.level_right);
				end
			end
			if (sample_ch.valid && sample_ch.ready === 1'b1) fold_sample(sample_ch.data);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready === 1'b1) ||
				(result_ch.valid === 1'b1 && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_sample(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r, input logic be);
		in_item_t s;
		s.left_sample  = l;
		s.right_sample = r;
		s.block_end    = be;
		sample_q = {sample_q, s};
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return SAMPLE_W'(int'($urandom_range(15)) - 8);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		while (sample_q.size() > 0 || sample_ch.valid || envelope_meter_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_item_t c;
		c.index = idx;
		c.value = val;
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= c;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_DECIMATION) decim = val;
		else if (idx == CFG_DECAY_GAIN) gain = val;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] ph_decim [8];
		logic [GAIN_W-1:0]     ph_gain [8];
		int                    ph_block [8];
		ph_decim = '{16'd2, 16'd5, 16'd1, 16'd65535, 16'd7, 16'd16, 16'd3, 16'd1};
		ph_gain  = '{GAIN_RESET, 16'(0), 16'hFFFF, 16'd1, 16'(0), 16'd0, 16'(0), 16'(0)};
		ph_block = '{12, 30, 5, 20, 50, 8, 12, 15};

		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		result_ch.ready = 1'b0;
		no_idle      = 1'b0;
		hold_go      = 1'b0;
		stall_cycles = 0;
		decim     = DECIM_RESET;
		gain      = GAIN_RESET;
		chunk_cnt = '0;
		mn_l = '0; mx_l = '0; mn_r = '0; mx_r = '0;
		pk_l = '0; pk_r = '0; lvl_l = '0; lvl_r = '0;
		slot = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, extremes, meter without point
		add_sample('0, '0, 1'b0);
		add_sample(S_MAX, S_MIN, 1'b0);
		add_sample(S_MIN, S_MAX, 1'b1);
		add_sample('0, '0, 1'b1);
		wait_idle();
		// factor dropped below the running count, full gain, unused index
		write_reg(CFG_DECIMATION, 16'd1);
		write_reg(CFG_DECAY_GAIN, 16'hFFFF);
		write_reg(CFG_SPARE_IDX, 16'h0005);
		add_sample(S_MAX, S_MAX, 1'b0);
		add_sample(S_MIN, S_MIN, 1'b1);
		add_sample(-24'sd1, 24'sd1, 1'b0);
		add_sample(24'sd1, -24'sd1, 1'b1);
		add_sample('0, '0, 1'b1);
		wait_idle();
		// factor zero, gain zero
		write_reg(CFG_DECIMATION, 16'd0);
		write_reg(CFG_DECAY_GAIN, 16'd0);
		add_sample(S_MIN, 24'sd7, 1'b1);
		add_sample(24'sd5, -24'sd5, 1'b0);
		add_sample(S_MAX, '0, 1'b1);
		wait_idle();
		write_reg(CFG_DECIMATION, 16'd3);
		write_reg(CFG_DECAY_GAIN, 16'd32768);
		add_sample(24'sd100, -24'sd100, 1'b0);
		add_sample(-24'sd200, 24'sd200, 1'b0);
		wait_idle();
		write_reg(CFG_DECIMATION, 16'd2);
		add_sample(24'sd1, 24'sd1, 1'b0);
		add_sample(24'sd2, 24'sd2, 1'b1);
		add_sample(24'sd3, 24'sd3, 1'b0);
		add_sample(24'sd4, 24'sd4, 1'b0);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_DECIMATION, ph_decim[p]);
			write_reg(CFG_DECAY_GAIN,
				(ph_gain[p] == 16'd0 && p != 5) ? 16'($urandom_range(65535)) : ph_gain[p]);
			@(posedge clk);
			no_idle <= (p == 2);
			hold_go <= (p == 7);
			for (int i = 0; i < 200; i++)
				add_sample(pick_sample(), pick_sample(), $urandom_range(99) < ph_block[p]);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
